// ----- src/thas_pkg.sv -----
// Package: word types, register indexes, reset values and shared helpers of the thermostat.
`default_nettype none
package thas_pkg;

  localparam int TEMP_W     = 12;
  localparam int NOW_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = 22;

  // probe readings count only strictly inside this window (32 F .. 185 F)
  localparam logic [TEMP_W-1:0] VALID_LOW  = 12'd512;
  localparam logic [TEMP_W-1:0] VALID_HIGH = 12'd2960;
  localparam logic [TEMP_W-1:0] HELD_RESET = 12'd512;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_ABOVE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_BELOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_TEMP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_BITS       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_DELAY   = 3'd7;

  localparam logic [11:0] RST_TARGET_TEMP     = 12'd960;
  localparam logic [11:0] RST_HYST_ABOVE      = 12'd8;
  localparam logic [11:0] RST_HYST_BELOW      = 12'd8;
  localparam logic [12:0] RST_BOOST_THRESHOLD = 13'd0;
  localparam logic [7:0]  RST_BOOST_GAIN      = 8'd32;
  localparam logic [11:0] RST_FLOOR_TEMP      = 12'd528;
  localparam logic [1:0]  RST_MODE_BITS       = 2'd0;
  localparam logic [15:0] RST_RESTART_DELAY   = 16'd60;

  localparam int MODE_HEATER = 0;
  localparam int MODE_SINGLE = 1;

  localparam logic [1:0] RELAY_UNKNOWN = 2'd0;
  localparam logic [1:0] RELAY_OFF     = 2'd1;
  localparam logic [1:0] RELAY_ON      = 2'd2;

  typedef struct packed {
    logic [TEMP_W-1:0] main_reading;
    logic [TEMP_W-1:0] chamber_reading;
    logic [NOW_W-1:0]  now_seconds;
  } in_word_t;

  typedef struct packed {
    logic              relay_on;
    logic              relay_known;
    logic              switched;
    logic              delay_blocked;
    logic [TEMP_W-1:0] action_temp;
    logic [TEMP_W-1:0] target_used;
  } out_word_t;

  typedef struct packed {
    logic [11:0] target_temp;
    logic [11:0] hyst_above;
    logic [11:0] hyst_below;
    logic [12:0] boost_threshold;  // two's complement
    logic [7:0]  boost_gain;       // 4.4 fixed point
    logic [11:0] floor_temp;
    logic [1:0]  mode_bits;
    logic [15:0] restart_delay;
  } cfg_t;

  // first stage result: chosen temperature and the raw target push product
  typedef struct packed {
    logic [TEMP_W-1:0] act_temp;
    logic              boost;
    logic [PROD_W-1:0] prod;       // two's complement err * gain
    logic [NOW_W-1:0]  now_seconds;
  } sel_t;

  function automatic logic is_valid(input logic [TEMP_W-1:0] t);
    return (t > VALID_LOW) && (t < VALID_HIGH);
  endfunction

endpackage
`default_nettype wire

// ----- src/thas_stream_if.sv -----
// Interface: valid/ready channel carrying one word.
`default_nettype none
interface thas_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/thermostat_hysteresis_asd_top.sv -----
// Top level: configuration registers, held probe values, two-stage pipeline and output register.
// Thermostat relay controller. One word per clock is taken on in_ch unless out_ch stalls; one
// result word leaves on out_ch for each, in order, via sel_r and out_r. The pipeline has two
// stages: the first keeps the last valid probe readings and forms the action
// temperature and the target push product, the second applies the push and clamp,
// the hysteresis bounds and the restart delay, and holds the relay state, whose
// feedback closes within that one stage. A stall on out_ch holds the whole pipeline;
// in_ch.ready is high whenever the output register is free or being drained.
// Registers are written through cfg_we/cfg_index/cfg_data and should only change
// while no word is in flight.
`default_nettype none
module thermostat_hysteresis_asd_top (
  input  logic                              clk,
  input  logic                              rst_n,
  thas_stream_if.sink                       in_ch,
  thas_stream_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [thas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [thas_pkg::CFG_DATA_W-1:0]   cfg_data
);

  thas_pkg::cfg_t             cfg_r;
  logic [thas_pkg::TEMP_W-1:0] held_main_r, held_main_nxt;
  logic [thas_pkg::TEMP_W-1:0] held_chamber_r, held_chamber_nxt;
  logic [1:0]                  relay_state_r, relay_state_nxt;
  logic [thas_pkg::NOW_W-1:0]  off_stamp_r, off_stamp_nxt;
  logic                        stage_valid_r;
  logic                        out_valid_r;
  thas_pkg::sel_t              sel, sel_r;
  thas_pkg::out_word_t         res, out_r;
  thas_pkg::in_word_t          in_word;
  logic                        advance;
  logic                        in_fire;

  assign in_word      = in_ch.data;
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = advance;
  assign in_fire      = in_ch.valid && advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign held_main_nxt    = thas_pkg::is_valid(in_word.main_reading) ?
                            in_word.main_reading : held_main_r;
  assign held_chamber_nxt = thas_pkg::is_valid(in_word.chamber_reading) ?
                            in_word.chamber_reading : held_chamber_r;

  thas_select u_select (
    .cfg          (cfg_r),
    .held_main    (held_main_nxt),
    .held_chamber (held_chamber_nxt),
    .now_seconds  (in_word.now_seconds),
    .sel          (sel)
  );

  thas_relay u_relay (
    .cfg             (cfg_r),
    .sel             (sel_r),
    .relay_state     (relay_state_r),
    .off_stamp       (off_stamp_r),
    .relay_state_nxt (relay_state_nxt),
    .off_stamp_nxt   (off_stamp_nxt),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_temp     <= thas_pkg::RST_TARGET_TEMP;
      cfg_r.hyst_above      <= thas_pkg::RST_HYST_ABOVE;
      cfg_r.hyst_below      <= thas_pkg::RST_HYST_BELOW;
      cfg_r.boost_threshold <= thas_pkg::RST_BOOST_THRESHOLD;
      cfg_r.boost_gain      <= thas_pkg::RST_BOOST_GAIN;
      cfg_r.floor_temp      <= thas_pkg::RST_FLOOR_TEMP;
      cfg_r.mode_bits       <= thas_pkg::RST_MODE_BITS;
      cfg_r.restart_delay   <= thas_pkg::RST_RESTART_DELAY;
    end else if (cfg_we) begin
      case (cfg_index)
        thas_pkg::REG_TARGET_TEMP:     cfg_r.target_temp     <= cfg_data[11:0];
        thas_pkg::REG_HYST_ABOVE:      cfg_r.hyst_above      <= cfg_data[11:0];
        thas_pkg::REG_HYST_BELOW:      cfg_r.hyst_below      <= cfg_data[11:0];
        thas_pkg::REG_BOOST_THRESHOLD: cfg_r.boost_threshold <= cfg_data[12:0];
        thas_pkg::REG_BOOST_GAIN:      cfg_r.boost_gain      <= cfg_data[7:0];
        thas_pkg::REG_FLOOR_TEMP:      cfg_r.floor_temp      <= cfg_data[11:0];
        thas_pkg::REG_MODE_BITS:       cfg_r.mode_bits       <= cfg_data[1:0];
        thas_pkg::REG_RESTART_DELAY:   cfg_r.restart_delay   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_main_r    <= thas_pkg::HELD_RESET;
      held_chamber_r <= thas_pkg::HELD_RESET;
      relay_state_r  <= thas_pkg::RELAY_UNKNOWN;
      off_stamp_r    <= '0;
      stage_valid_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else if (advance) begin
      stage_valid_r <= in_fire;
      out_valid_r   <= stage_valid_r;
      if (in_fire) begin
        held_main_r    <= held_main_nxt;
        held_chamber_r <= held_chamber_nxt;
      end
      if (stage_valid_r) begin
        relay_state_r <= relay_state_nxt;
        off_stamp_r   <= off_stamp_nxt;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_fire) sel_r <= sel;
      if (stage_valid_r) out_r <= res;
    end
  end

endmodule
`default_nettype wire

// ----- src/thas_select.sv -----
// Probe selection, error and target push product (first stage logic).
`default_nettype none
module thas_select (
  input  thas_pkg::cfg_t              cfg,
  input  logic [thas_pkg::TEMP_W-1:0] held_main,
  input  logic [thas_pkg::TEMP_W-1:0] held_chamber,
  input  logic [thas_pkg::NOW_W-1:0]  now_seconds,
  output thas_pkg::sel_t              sel
);

  logic                              main_ok;
  logic                              chamber_ok;
  logic                              heater;
  logic [thas_pkg::TEMP_W:0]         sum;
  logic signed [12:0]                err;
  logic signed [8:0]                 gain_s;
  logic signed [thas_pkg::PROD_W-1:0] prod;

  assign main_ok    = thas_pkg::is_valid(held_main);
  assign chamber_ok = thas_pkg::is_valid(held_chamber);
  assign heater     = cfg.mode_bits[thas_pkg::MODE_HEATER];
  assign sum        = {1'b0, held_main} + {1'b0, held_chamber};
  assign gain_s     = $signed({1'b0, cfg.boost_gain});

  always_comb begin
    sel.act_temp    = cfg.target_temp;
    sel.boost       = 1'b0;
    sel.now_seconds = now_seconds;
    err             = '0;
    if (cfg.mode_bits[thas_pkg::MODE_SINGLE]) begin
      case ({main_ok, chamber_ok})
        2'b11:   sel.act_temp = sum[thas_pkg::TEMP_W:1];
        2'b10:   sel.act_temp = held_main;
        2'b01:   sel.act_temp = held_chamber;
        default: sel.act_temp = cfg.target_temp;
      endcase
    end else if (!chamber_ok) begin
      sel.act_temp = held_main;
    end else begin
      sel.act_temp = held_chamber;
      if (heater) begin
        err = $signed({1'b0, cfg.target_temp}) - $signed({1'b0, held_chamber});
      end else begin
        err = $signed({1'b0, held_chamber}) - $signed({1'b0, cfg.target_temp});
      end
      sel.boost = (err >= $signed(cfg.boost_threshold));
    end
  end

  assign prod     = err * gain_s;
  assign sel.prod = prod;

endmodule
`default_nettype wire

// ----- src/thas_relay.sv -----
// Target push and clamp, hysteresis compare, relay decision and restart delay (second stage).
`default_nettype none
module thas_relay (
  input  thas_pkg::cfg_t              cfg,
  input  thas_pkg::sel_t              sel,
  input  logic [1:0]                  relay_state,
  input  logic [thas_pkg::NOW_W-1:0]  off_stamp,
  output logic [1:0]                  relay_state_nxt,
  output logic [thas_pkg::NOW_W-1:0]  off_stamp_nxt,
  output thas_pkg::out_word_t         res
);

  logic                       heater;
  logic signed [17:0]         push;
  logic signed [19:0]         base;
  logic signed [19:0]         pushed;
  logic signed [19:0]         floored;
  logic [thas_pkg::TEMP_W-1:0] tgt;
  logic [12:0]                hi;
  logic signed [13:0]         lo;
  logic                       above_hi;
  logic                       below_lo;
  logic                       decide;
  logic                       want_on;
  logic [thas_pkg::NOW_W-1:0] since_off;
  logic                       blocked;
  logic [1:0]                 target_state;

  assign heater = cfg.mode_bits[thas_pkg::MODE_HEATER];

  // floor of product / 16 is the arithmetic shift
  assign push   = $signed(sel.prod[thas_pkg::PROD_W-1:4]);
  assign base   = $signed({8'b0, cfg.target_temp});
  assign pushed = heater ? (base + 20'(push)) : (base - 20'(push));

  always_comb begin
    floored = pushed;
    if (floored < $signed({8'b0, cfg.floor_temp})) floored = $signed({8'b0, cfg.floor_temp});
    if (floored < 20'sd0) floored = 20'sd0;
    if (floored > 20'sd4095) floored = 20'sd4095;
    tgt = sel.boost ? floored[thas_pkg::TEMP_W-1:0] : cfg.target_temp;
  end

  assign hi       = {1'b0, tgt} + {1'b0, cfg.hyst_above};
  assign lo       = $signed({2'b0, tgt}) - $signed({2'b0, cfg.hyst_below});
  assign above_hi = {1'b0, sel.act_temp} > hi;
  assign below_lo = $signed({2'b0, sel.act_temp}) < lo;

  always_comb begin
    case (relay_state)
      thas_pkg::RELAY_ON: begin
        decide  = heater ? above_hi : below_lo;
        want_on = 1'b0;
      end
      thas_pkg::RELAY_OFF: begin
        decide  = heater ? below_lo : above_hi;
        want_on = 1'b1;
      end
      default: begin
        decide  = 1'b1;
        want_on = heater ? below_lo : above_hi;
      end
    endcase
  end

  assign since_off    = sel.now_seconds - off_stamp;
  assign blocked      = decide && want_on && (since_off < {16'b0, cfg.restart_delay});
  assign target_state = want_on ? thas_pkg::RELAY_ON : thas_pkg::RELAY_OFF;

  always_comb begin
    relay_state_nxt = relay_state;
    off_stamp_nxt   = off_stamp;
    res.switched    = 1'b0;
    if (decide && !blocked && (target_state != relay_state)) begin
      relay_state_nxt = target_state;
      res.switched    = 1'b1;
      if (target_state == thas_pkg::RELAY_OFF) off_stamp_nxt = sel.now_seconds;
    end
    res.relay_on      = (relay_state_nxt == thas_pkg::RELAY_ON);
    res.relay_known   = (relay_state_nxt == thas_pkg::RELAY_ON) ||
                        (relay_state_nxt == thas_pkg::RELAY_OFF);
    res.delay_blocked = blocked;
    res.action_temp   = sel.act_temp;
    res.target_used   = tgt;
  end

endmodule
`default_nettype wire

// ----- verif/tb_thermostat_hysteresis_asd_top.sv -----
// Testbench for the thermostat relay controller: random and directed ticks, scored against a predictor.
`timescale 1ns / 100ps

module tb_thermostat_hysteresis_asd_top;
  import thas_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  thas_stream_if #(.word_t(in_word_t))  in_ch ();
  thas_stream_if #(.word_t(out_word_t)) out_ch ();

  thermostat_hysteresis_asd_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state and register copy
  cfg_t              cfg_now;
  logic [TEMP_W-1:0] held_main, held_chamber;
  logic [1:0]        relay_st;
  logic [NOW_W-1:0]  off_stamp;

  in_word_t  ticks_to_send[$];
  out_word_t decisions_due[$];
  int        mismatch_count;
  int        sender_gap_pct, sink_stall_pct;
  int        hold_left;
  int        stall_cycles;
  logic      word_taken;
  logic [NOW_W-1:0] clock_s;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic probe_ok(input logic [TEMP_W-1:0] x);
    return (x > VALID_LOW) && (x < VALID_HIGH);
  endfunction

  function automatic out_word_t relay_decision(input in_word_t w);
    out_word_t        r;
    logic             heater, single;
    int               t, tgt, hi, lo, err, acc, n, thr, gain, hyst_a, hyst_b, floor_v, want_on;
    logic [NOW_W-1:0] since_off;
    logic [1:0]       next_st;
    heater  = cfg_now.mode_bits[MODE_HEATER];
    single  = cfg_now.mode_bits[MODE_SINGLE];
    thr     = int'($signed(cfg_now.boost_threshold));
    gain    = int'(cfg_now.boost_gain);
    hyst_a  = int'(cfg_now.hyst_above);
    hyst_b  = int'(cfg_now.hyst_below);
    floor_v = int'(cfg_now.floor_temp);
    want_on = -1;
    r = '0;
    if (probe_ok(w.main_reading)) held_main = w.main_reading;
    if (probe_ok(w.chamber_reading)) held_chamber = w.chamber_reading;
    tgt = int'(cfg_now.target_temp);
    if (single) begin
      acc = 0;
      n = 0;
      if (probe_ok(held_main)) begin
        acc += int'(held_main);
        n++;
      end
      if (probe_ok(held_chamber)) begin
        acc += int'(held_chamber);
        n++;
      end
      t = (n == 0) ? tgt : acc / n;
    end else if (!probe_ok(held_chamber)) begin
      // no usable chamber reading yet: main value taken as is, valid or not
      t = int'(held_main);
    end else begin
      t = int'(held_chamber);
      err = heater ? tgt - t : t - tgt;
      if (err >= thr) begin
        // arithmetic shift gives the floor of err * gain / 16
        tgt = heater ? tgt + ((err * gain) >>> 4) : tgt - ((err * gain) >>> 4);
        if (tgt < floor_v) tgt = floor_v;
        if (tgt < 0) tgt = 0;
        if (tgt > 4095) tgt = 4095;
      end
    end
    hi = tgt + hyst_a;
    lo = tgt - hyst_b;
    if (relay_st != RELAY_ON && relay_st != RELAY_OFF) begin
      want_on = heater ? int'(t < lo) : int'(t > hi);
    end else if (relay_st == RELAY_ON) begin
      if (heater ? (t > hi) : (t < lo)) want_on = 0;
    end else begin
      if (heater ? (t < lo) : (t > hi)) want_on = 1;
    end
    since_off = w.now_seconds - off_stamp;
    if (want_on == 1 && since_off < NOW_W'(cfg_now.restart_delay)) begin
      r.delay_blocked = 1'b1;
    end else if (want_on >= 0) begin
      next_st = (want_on == 1) ? RELAY_ON : RELAY_OFF;
      if (next_st != relay_st) begin
        relay_st = next_st;
        r.switched = 1'b1;
        if (next_st == RELAY_OFF) off_stamp = w.now_seconds;
      end
    end
    r.relay_on    = (relay_st == RELAY_ON);
    r.relay_known = (relay_st == RELAY_ON) || (relay_st == RELAY_OFF);
    r.action_temp = t[TEMP_W-1:0];
    r.target_used = tgt[TEMP_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // sender: holds the word until taken
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || word_taken)) begin
      if (ticks_to_send.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
        in_ch.data  <= ticks_to_send.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : score_p
    out_word_t want;
    word_taken <= in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decisions_due.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
      end else begin
        want = decisions_due.pop_front();
        check_field("relay_on", 32'(want.relay_on), 32'(out_ch.data.relay_on));
        check_field("relay_known", 32'(want.relay_known), 32'(out_ch.data.relay_known));
        check_field("switched", 32'(want.switched), 32'(out_ch.data.switched));
        check_field("delay_blocked", 32'(want.delay_blocked), 32'(out_ch.data.delay_blocked));
        check_field("action_temp", 32'(want.action_temp), 32'(out_ch.data.action_temp));
        check_field("target_used", 32'(want.target_used), 32'(out_ch.data.target_used));
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) decisions_due.push_back(relay_decision(in_ch.data));
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one register write, returns on a rising edge so queue pushes never meet the sender
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET_TEMP:     cfg_now.target_temp     = v[11:0];
      REG_HYST_ABOVE:      cfg_now.hyst_above      = v[11:0];
      REG_HYST_BELOW:      cfg_now.hyst_below      = v[11:0];
      REG_BOOST_THRESHOLD: cfg_now.boost_threshold = v[12:0];
      REG_BOOST_GAIN:      cfg_now.boost_gain      = v[7:0];
      REG_FLOOR_TEMP:      cfg_now.floor_temp      = v[11:0];
      REG_MODE_BITS:       cfg_now.mode_bits       = v[1:0];
      REG_RESTART_DELAY:   cfg_now.restart_delay   = v[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(REG_TARGET_TEMP, CFG_DATA_W'(c.target_temp));
    write_reg(REG_HYST_ABOVE, CFG_DATA_W'(c.hyst_above));
    write_reg(REG_HYST_BELOW, CFG_DATA_W'(c.hyst_below));
    write_reg(REG_BOOST_THRESHOLD, CFG_DATA_W'(c.boost_threshold));
    write_reg(REG_BOOST_GAIN, CFG_DATA_W'(c.boost_gain));
    write_reg(REG_FLOOR_TEMP, CFG_DATA_W'(c.floor_temp));
    write_reg(REG_MODE_BITS, CFG_DATA_W'(c.mode_bits));
    write_reg(REG_RESTART_DELAY, c.restart_delay);
  endtask

  function automatic cfg_t draw_settings(input logic [1:0] mode);
    cfg_t c;
    int   thr;
    c.target_temp   = 12'($urandom_range(600, 2400));
    c.hyst_above    = 12'($urandom_range(0, 48));
    c.hyst_below    = 12'($urandom_range(0, 48));
    thr             = int'($urandom_range(0, 400)) - 200;
    c.boost_threshold = thr[12:0];
    c.boost_gain    = 8'($urandom_range(0, 255));
    c.floor_temp    = 12'($urandom_range(0, c.target_temp));
    c.mode_bits     = mode;
    c.restart_delay = 16'($urandom_range(0, 120));
    return c;
  endfunction

  function automatic logic [TEMP_W-1:0] pick_reading();
    int pick, v;
    int edges[8] = '{0, 511, 512, 513, 2959, 2960, 2961, 4095};
    pick = $urandom_range(0, 99);
    if (pick < 45) v = int'(cfg_now.target_temp) + int'($urandom_range(0, 160)) - 80;
    else if (pick < 65) v = $urandom_range(513, 2959);
    else if (pick < 80) v = $urandom_range(0, 1) ? $urandom_range(0, 512) : $urandom_range(2960, 4095);
    else if (pick < 88) v = edges[$urandom_range(0, 7)];
    else v = $urandom_range(0, 4095);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[TEMP_W-1:0];
  endfunction

  function automatic in_word_t pack_tick(input int m, input int c, input int s);
    in_word_t w;
    w.main_reading    = m[TEMP_W-1:0];
    w.chamber_reading = c[TEMP_W-1:0];
    w.now_seconds     = s;
    return w;
  endfunction

  task automatic queue_random_ticks(input int count);
    in_word_t w;
    int       pick, span;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      span = int'(cfg_now.restart_delay);
      // mostly small time steps so that the restart delay both blocks and expires
      if (pick < 80) clock_s += $urandom_range(0, 2 * span + 4);
      else if (pick < 95) clock_s += $urandom_range(0, 2);
      else clock_s = $urandom();
      w.main_reading    = pick_reading();
      w.chamber_reading = pick_reading();
      w.now_seconds     = clock_s;
      ticks_to_send.push_back(w);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (ticks_to_send.size() != 0 || in_ch.valid || decisions_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input cfg_t c, input int gap_pct, input int stall_pct,
                           input int hold, input int count);
    load_settings(c);
    sender_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    if (hold > 0) hold_left = hold;
    queue_random_ticks(count / 2);
    wait_drained();
    queue_random_ticks(count - count / 2);
    wait_drained();
  endtask

  initial begin
    cfg_t c;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    word_taken     = 1'b0;
    stall_cycles   = 0;
    hold_left      = 0;
    mismatch_count = 0;
    sender_gap_pct = 10;
    sink_stall_pct = 69;
    clock_s        = 402;
    cfg_now = '{target_temp: RST_TARGET_TEMP, hyst_above: RST_HYST_ABOVE,
                hyst_below: RST_HYST_BELOW, boost_threshold: RST_BOOST_THRESHOLD,
                boost_gain: RST_BOOST_GAIN, floor_temp: RST_FLOOR_TEMP,
                mode_bits: RST_MODE_BITS, restart_delay: RST_RESTART_DELAY};
    held_main    = HELD_RESET;
    held_chamber = HELD_RESET;
    relay_st     = RELAY_UNKNOWN;
    off_stamp    = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dual cooler, nothing valid yet: invalid main drives a turn-on that the delay holds off
    write_reg(REG_TARGET_TEMP, 16'd400);
    ticks_to_send.push_back(pack_tick(0, 4095, 5));
    wait_drained();
    // single cooler: no valid probe, then one, then the mean of both
    write_reg(REG_MODE_BITS, 16'd2);
    ticks_to_send.push_back(pack_tick(512, 2960, 10));
    ticks_to_send.push_back(pack_tick(1000, 0, 20));
    ticks_to_send.push_back(pack_tick(511, 1200, 80));
    wait_drained();
    // single heater
    write_reg(REG_TARGET_TEMP, 16'(RST_TARGET_TEMP));
    write_reg(REG_MODE_BITS, 16'd3);
    ticks_to_send.push_back(pack_tick(2959, 513, 90));
    ticks_to_send.push_back(pack_tick(513, 600, 100));
    ticks_to_send.push_back(pack_tick(600, 600, 200));
    wait_drained();
    // dual heater: push raises the target, then a drop below threshold
    write_reg(REG_MODE_BITS, 16'd1);
    ticks_to_send.push_back(pack_tick(0, 900, 210));
    ticks_to_send.push_back(pack_tick(0, 2959, 220));
    wait_drained();
    // dual cooler: push clamped at the floor, error exactly at threshold
    write_reg(REG_MODE_BITS, 16'd0);
    ticks_to_send.push_back(pack_tick(4095, 2000, 300));
    ticks_to_send.push_back(pack_tick(0, 513, 400));
    ticks_to_send.push_back(pack_tick(4095, 4095, 401));
    ticks_to_send.push_back(pack_tick(0, 960, 402));
    ticks_to_send.push_back(pack_tick(2961, 4095, 402));
    wait_drained();

    run_phase(draw_settings(2'($urandom_range(0, 3))), 10, 69, 0, 155);
    c = '{target_temp: 12'd0, hyst_above: 12'd0, hyst_below: 12'd0,
          boost_threshold: 13'h0FFF, boost_gain: 8'd0, floor_temp: 12'd0,
          mode_bits: 2'd0, restart_delay: 16'd0};
    run_phase(c, 10, 69, 0, 155);
    // receiver holds off long enough for the pipeline to back up into the input
    run_phase(draw_settings(2'd0), 69, 10, 300, 155);
    c = '{target_temp: 12'd4095, hyst_above: 12'd4095, hyst_below: 12'd4095,
          boost_threshold: 13'h1001, boost_gain: 8'd255, floor_temp: 12'd4095,
          mode_bits: 2'd1, restart_delay: 16'hFFFF};
    run_phase(c, 69, 10, 0, 155);
    clock_s = 32'hFFFF_FF00;   // seconds counter wraps within this phase
    run_phase(draw_settings(2'd2), 0, 0, 0, 155);
    run_phase(draw_settings(2'd3), 0, 0, 0, 155);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && decisions_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
